// ===== hdl/coe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package coe_pkg;

  localparam int NUM_CLAUSES_DEF = 64;
  localparam int MAX_CHUNKS_DEF  = 8;

  localparam int CLAUSE_W = 6;
  localparam int CHUNK_W  = 3;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int OUT_W    = 64;

  localparam logic [WORD_W-1:0]  FULL_WORD          = 32'hffff_ffff;
  localparam logic [COUNT_W-1:0] LITERAL_COUNT_INIT = 9'd256;

  // register index, taken from paddr[2]
  localparam logic REG_LITERAL_COUNT = 1'b0;
  localparam logic REG_PREDICT_MODE  = 1'b1;

  // word kinds on s_tuser
  localparam logic ACT_INCLUDE = 1'b0;
  localparam logic ACT_LITERAL = 1'b1;

  // control of the merge stage
  typedef struct packed {
    logic valid;        // a literal chunk in range sits in the merge stage
    logic chunk_end;    // it is the last chunk of its patch
    logic example_end;  // and the patch is the last of the example
  } coe_stage_t;

endpackage

`default_nettype wire

// ===== hdl/coe_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One clause: include words for every chunk, registered read, match test.
module coe_lane #(
  parameter int DEPTH = coe_pkg::MAX_CHUNKS_DEF,
  parameter int AW    = 3
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [coe_pkg::WORD_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  input  wire logic [coe_pkg::WORD_W-1:0]  filter,
  input  wire logic [coe_pkg::WORD_W-1:0]  literals,
  output logic                             mismatch,
  output logic                             nonempty
);

  logic [coe_pkg::WORD_W-1:0] mem [DEPTH];
  logic [coe_pkg::WORD_W-1:0] rdata;
  logic [coe_pkg::WORD_W-1:0] inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign inc      = rdata & filter;
  assign mismatch = |(inc & ~literals);
  assign nonempty = |inc;

endmodule

`default_nettype wire

// ===== hdl/coe_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Folds the lane results into per-patch and per-example state; holds the result word.
module coe_merge #(
  parameter int NUM_CLAUSES = coe_pkg::NUM_CLAUSES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire coe_pkg::coe_stage_t         stage,
  input  wire logic [NUM_CLAUSES-1:0]      lane_mismatch,
  input  wire logic [NUM_CLAUSES-1:0]      lane_nonempty,
  input  wire logic                        predict_mode,
  output logic                             go,
  output logic                             out_valid,
  output logic [NUM_CLAUSES-1:0]           out_data,
  input  wire logic                        out_ready
);

  logic [NUM_CLAUSES-1:0] patch_match;
  logic [NUM_CLAUSES-1:0] clause_nonempty;
  logic [NUM_CLAUSES-1:0] example_hit;
  logic [NUM_CLAUSES-1:0] patch_match_next;
  logic [NUM_CLAUSES-1:0] nonempty_next;
  logic [NUM_CLAUSES-1:0] example_hit_next;
  logic                   update;

  always_comb begin
    patch_match_next = patch_match & ~lane_mismatch;
    nonempty_next    = clause_nonempty | lane_nonempty;
    example_hit_next = example_hit |
                       (patch_match_next & (predict_mode ? nonempty_next : '1));
  end

  // only a result that finds the output word still occupied holds the stage
  assign go     = !(stage.valid && stage.chunk_end && stage.example_end &&
                    out_valid && !out_ready);
  assign update = stage.valid && go;

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_match     <= '1;
      clause_nonempty <= '0;
      example_hit     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (update) begin
        if (stage.chunk_end) begin
          patch_match     <= '1;
          clause_nonempty <= '0;
          if (stage.example_end) begin
            example_hit <= '0;
            out_valid   <= 1'b1;
          end else begin
            example_hit <= example_hit_next;
          end
        end else begin
          patch_match     <= patch_match_next;
          clause_nonempty <= nonempty_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update && stage.chunk_end && stage.example_end) begin
      out_data <= example_hit_next;
    end
  end

  a_patch_restart: assert property (@(posedge clk) disable iff (rst)
    (update && stage.chunk_end) |=> (patch_match == '1 && clause_nonempty == '0))
    else $error("patch state not restarted after patch end");

  a_example_restart: assert property (@(posedge clk) disable iff (rst)
    (update && stage.chunk_end && stage.example_end) |=> (example_hit == '0 && out_valid))
    else $error("example end did not post a result and clear hits");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage.valid && stage.chunk_end && stage.example_end))
    else $error("result word appeared without an example end");

endmodule

`default_nettype wire

// ===== hdl/clause_output_evaluation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Clause evaluation of a Tsetlin machine. Include words (one per clause and
// 32-literal chunk) are loaded with s_tuser = 0; literal chunks of each patch
// follow with s_tuser = 1, in chunk order, s_tlast marking the last patch of
// the example. Each clause has its own lane with its own include memory, so
// all clauses test one chunk in the same cycle and the port takes one word per
// clock unless stalled. The lane memories are read as a chunk enters the merge
// stage, and the chunk is folded into the clause state as it leaves, so the
// clause output word of an example is registered onto m_tdata as its last
// chunk leaves the merge stage. Only the output word can stall the flow, and
// only when a second result is ready before the first is taken. After reset a
// clearing pass zeroes the include memories, one chunk address in all lanes
// per cycle, over min(MAX_CHUNKS, 8) addresses; s_tready stays low until it
// ends. The configuration registers (literal count at 0x0, predict_mode at 0x4)
// are for the user to write only while the stream is idle; the block does not enforce it.
module clause_output_evaluation #(
  parameter int NUM_CLAUSES = coe_pkg::NUM_CLAUSES_DEF,
  parameter int MAX_CHUNKS  = coe_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // clause_index[5:0], chunk_index[8:6], word_value[40:9]
  input  wire logic        s_tuser,   // action
  input  wire logic        s_tlast,   // last_patch
  // result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata    // clause_word[63:0]
);

  // chunk_index is 3 bits wide, so no more than eight chunks are reachable
  localparam int REACH = (MAX_CHUNKS < 8) ? MAX_CHUNKS : 8;
  localparam int AW    = (REACH > 1) ? $clog2(REACH) : 1;
  localparam logic [coe_pkg::COUNT_W-1:0] LIT_LIMIT = coe_pkg::COUNT_W'(32 * REACH);

  // input word fields
  logic [coe_pkg::CLAUSE_W-1:0] clause_index;
  logic [coe_pkg::CHUNK_W-1:0]  chunk_index;
  logic [coe_pkg::WORD_W-1:0]   word_value;

  assign clause_index = s_tdata[5:0];
  assign chunk_index  = s_tdata[8:6];
  assign word_value   = s_tdata[40:9];

  // configuration registers
  logic [coe_pkg::COUNT_W-1:0] lit_total;
  logic                        predict_mode;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_total    <= coe_pkg::LITERAL_COUNT_INIT;
      predict_mode <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[2])
        coe_pkg::REG_LITERAL_COUNT: lit_total    <= pwdata[8:0];
        coe_pkg::REG_PREDICT_MODE:  predict_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      coe_pkg::REG_LITERAL_COUNT: prdata = 32'(lit_total);
      coe_pkg::REG_PREDICT_MODE:  prdata = 32'(predict_mode);
      default:                    prdata = '0;
    endcase
  end

  // literal count: 0 counts as 1, saturates at the reachable chunks
  logic [coe_pkg::COUNT_W-1:0] used_count;
  logic [coe_pkg::COUNT_W-1:0] used_less;
  logic [coe_pkg::CHUNK_W-1:0] last_chunk;
  logic [4:0]                  rem;
  logic [coe_pkg::WORD_W-1:0]  tail_filter;

  always_comb begin
    if (lit_total == '0) begin
      used_count = coe_pkg::COUNT_W'(1);
    end else if (lit_total > LIT_LIMIT) begin
      used_count = LIT_LIMIT;
    end else begin
      used_count = lit_total;
    end
    used_less   = used_count - coe_pkg::COUNT_W'(1);
    last_chunk  = used_less[7:5];
    rem         = used_count[4:0];
    tail_filter = (rem == 5'd0) ? coe_pkg::FULL_WORD : ~(coe_pkg::FULL_WORD << rem);
  end

  // clearing pass over the lane memories
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(REACH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // accept side
  coe_pkg::coe_stage_t         stage;
  logic [coe_pkg::WORD_W-1:0]  stage_filter;
  logic [coe_pkg::WORD_W-1:0]  stage_word;
  logic                        go;
  logic                        accept;
  logic                        take_literal;
  logic                        take_include;
  logic                        chunk_live;

  assign s_tready     = !clearing && (!stage.valid || go);
  assign accept       = s_tvalid && s_tready;
  assign take_literal = accept && (s_tuser == coe_pkg::ACT_LITERAL);
  assign take_include = accept && (s_tuser == coe_pkg::ACT_INCLUDE) &&
                        (32'(clause_index) < NUM_CLAUSES) &&
                        (32'(chunk_index) < MAX_CHUNKS);
  // last_chunk never exceeds REACH-1, so this also keeps chunks inside MAX_CHUNKS
  assign chunk_live   = chunk_index <= last_chunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else if (take_literal) begin
      stage.valid       <= chunk_live;
      stage.chunk_end   <= chunk_index == last_chunk;
      stage.example_end <= s_tlast;
    end else if (go) begin
      stage.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_literal) begin
      stage_filter <= (chunk_index == last_chunk) ? tail_filter : coe_pkg::FULL_WORD;
      stage_word   <= word_value;
    end
  end

  // lanes: one clause each
  logic [NUM_CLAUSES-1:0] lane_mismatch;
  logic [NUM_CLAUSES-1:0] lane_nonempty;
  logic [AW-1:0]          wr_addr;
  logic [coe_pkg::WORD_W-1:0] wr_data;

  assign wr_addr = clearing ? clr_addr : AW'(chunk_index);
  assign wr_data = clearing ? '0 : word_value;

  for (genvar j = 0; j < NUM_CLAUSES; j++) begin : g_lane
    logic lane_wr;
    assign lane_wr = clearing ||
                     (take_include && (clause_index == coe_pkg::CLAUSE_W'(j)));

    coe_lane #(
      .DEPTH (REACH),
      .AW    (AW)
    ) u_lane (
      .clk      (clk),
      .wr_en    (lane_wr),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (take_literal),
      .rd_addr  (AW'(chunk_index)),
      .filter   (stage_filter),
      .literals (stage_word),
      .mismatch (lane_mismatch[j]),
      .nonempty (lane_nonempty[j])
    );
  end

  // merge of the lanes and result word
  logic [NUM_CLAUSES-1:0] result_bits;

  coe_merge #(
    .NUM_CLAUSES (NUM_CLAUSES)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .stage         (stage),
    .lane_mismatch (lane_mismatch),
    .lane_nonempty (lane_nonempty),
    .predict_mode  (predict_mode),
    .go            (go),
    .out_valid     (m_tvalid),
    .out_data      (result_bits),
    .out_ready     (m_tready)
  );

  assign m_tdata = coe_pkg::OUT_W'(result_bits);

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("word accepted during clearing pass");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && !go) |=> (stage.valid && $stable(stage_word) && $stable(stage_filter)))
    else $error("stalled chunk lost from merge stage");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (stage.valid && !go) |-> !s_tready)
    else $error("input taken while merge stage is stalled");

endmodule

`default_nettype wire
